[rtl/mpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_pkg: shared types and constants of the price forecast network
// Weights, normalisation constants and the tanh table.
// ----------------------------------------------------------------------------
package mpf_pkg;

  localparam int NumIn  = 6;
  localparam int NumHid = 6;
  localparam int NumOut = 3;

  // Q16 activation words; the volume input reaches 34 bits
  typedef logic signed [35:0] act_t;
  // wide accumulators
  typedef logic signed [63:0] acc_t;

  typedef act_t act_vec_t [NumIn];

  function automatic logic signed [18:0] hid_w(input int k, input int j);
    logic signed [18:0] w [6][7];
    w[0] = '{-19'sd32357, 19'sd86042, 19'sd140955, -19'sd58339, -19'sd24975,
             19'sd55757, 19'sd70237};
    w[1] = '{-19'sd25434, 19'sd36691, 19'sd44238, 19'sd51618, 19'sd2409, -19'sd50725,
             19'sd15805};
    w[2] = '{-19'sd35266, 19'sd17623, 19'sd25321, -19'sd32140, -19'sd48939, -19'sd5832,
             19'sd7296};
    w[3] = '{-19'sd112029, -19'sd19989, -19'sd669, -19'sd4394, 19'sd53805, 19'sd27765,
             19'sd195};
    w[4] = '{-19'sd23380, -19'sd68107, -19'sd49765, 19'sd12482, -19'sd26825, -19'sd69048,
             -19'sd42963};
    w[5] = '{19'sd98725, 19'sd25804, 19'sd24194, 19'sd53552, 19'sd4623, -19'sd30796,
             -19'sd11439};
    return w[k][j];
  endfunction

  function automatic logic signed [18:0] out_w(input int k, input int j);
    logic signed [18:0] w [3][7];
    w[0] = '{-19'sd1457, -19'sd4986, 19'sd24609, -19'sd55199, 19'sd48743, -19'sd7708,
             19'sd30554};
    w[1] = '{19'sd19, -19'sd13912, 19'sd37213, -19'sd50761, 19'sd49959, -19'sd6937,
             19'sd34880};
    w[2] = '{-19'sd93, -19'sd9023, 19'sd29827, -19'sd52964, 19'sd50571, -19'sd7526,
             19'sd32434};
    return w[k][j];
  endfunction

  function automatic logic [16:0] tanh_tab(input logic [4:0] i);
    logic [16:0] t [25];
    t = '{17'd0, 17'd16051, 17'd30285, 17'd41625, 17'd49912, 17'd55593, 17'd59320,
          17'd61694, 17'd63179, 17'd64096, 17'd64659, 17'd65003, 17'd65212, 17'd65339,
          17'd65417, 17'd65464, 17'd65492, 17'd65509, 17'd65520, 17'd65526, 17'd65530,
          17'd65532, 17'd65534, 17'd65535, 17'd65535};
    return (i < 5'd25) ? t[i] : 17'd65535;
  endfunction

  localparam longint InMean30 [4] = '{1326769085, 1333104162, 1320498433, 1326887196};
  localparam longint InInvDev [4] = '{99386380, 99142060, 99763430, 99485389};
  localparam longint OutMean30[3] = '{1333157849, 1320562857, 1326940884};
  localparam longint OutDev24 [3] = '{2837581, 2819814, 2827749};

  // round half up shift of a signed 64-bit value
  function automatic acc_t rnd_shift(input acc_t v, input int s);
    acc_t r;
    if (s == 0) begin
      r = v;
    end else begin
      r = (v + (acc_t'(1) <<< (s - 1))) >>> s;
    end
    return r;
  endfunction

  // valid bit and timestamp travelling beside the datapath
  typedef struct packed {
    logic        valid;
    logic [30:0] tstamp;
  } tag_t;

endpackage

[rtl/mpf_norm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_norm: input normalisation
// Two stages: subtract and multiply, then round to Q16.
// ----------------------------------------------------------------------------
module mpf_norm
  import mpf_pkg::*;
#(
  parameter int PRICE_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] t_in,
  input  logic [31:0] p_in [4],
  input  logic [31:0] v_in,
  output act_t        z_out [NumIn]
);

  acc_t prod_r [NumIn];
  act_t z_r    [NumIn];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= (acc_t'({1'b0, t_in}) - 64'sd1226070000) * 64'sd1916086;
      for (int k = 0; k < 4; k++) begin
        prod_r[1+k] <= (acc_t'({1'b0, p_in[k]})
                        - rnd_shift(acc_t'(InMean30[k]), 30 - PRICE_FRAC_BITS))
                       * acc_t'(InInvDev[k]);
      end
      prod_r[5] <= (acc_t'({v_in, 1'b0}) - 64'sd110077) * 64'sd8969586;
      z_r[0] <= act_t'(rnd_shift(prod_r[0], 32));
      for (int k = 1; k < 5; k++) begin
        z_r[k] <= act_t'(rnd_shift(prod_r[k], PRICE_FRAC_BITS + 8));
      end
      z_r[5] <= act_t'(rnd_shift(prod_r[5], 24));
    end
  end

  assign z_out = z_r;

endmodule

[rtl/mpf_mac_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_mac_cell: one multiply-accumulate cell of a neuron chain
// Adds weight times its input to the sum handed in by the left neighbour.
// ----------------------------------------------------------------------------
module mpf_mac_cell
  import mpf_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [18:0] w,
  input  act_t               x,
  input  acc_t               sum_in,
  output acc_t               sum_out
);

  acc_t sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_in + acc_t'(w) * acc_t'(x);
    end
  end

  assign sum_out = sum_r;

endmodule

[rtl/mpf_tanh.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_tanh: rounding to Q16 and table tanh with linear interpolation
// ----------------------------------------------------------------------------
module mpf_tanh
  import mpf_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  acc_t acc_in,
  output act_t h_out
);

  acc_t        x;
  logic        neg;
  acc_t        a;
  logic [4:0]  idx;
  logic [13:0] frac;
  logic [16:0] lo, hi;
  logic [31:0] mag;
  act_t        h_r;

  always_comb begin
    x    = rnd_shift(acc_in, 16);
    neg  = x[63];
    a    = neg ? -x : x;
    idx  = a[18:14];
    frac = a[13:0];
    lo   = tanh_tab(idx);
    hi   = tanh_tab(idx + 5'd1);
    if (a[62:14] >= 49'd24) begin
      mag = 32'd65535;
    end else begin
      mag = 32'(lo) + 32'((32'(hi - lo) * 32'(frac) + 32'd8192) >> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= neg ? -act_t'(mag) : act_t'(mag);
    end
  end

  assign h_out = h_r;

endmodule

[rtl/mlp_price_forecast.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_price_forecast: 6-6-3 tanh network forecasting the next price bar
// One bar request in, one forecast request out; timestamp passes through.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one bar (time, OHLC, volume) per request.
//   out_valid/out_ready carry the forecast (time, predicted high/low/close).
//   Throughput is one bar per cycle while the receiver does not stall.
//   Eighteen register stages: 2 normalisation stages, a chain of 6 MAC
//   cells per hidden neuron, 1 tanh stage, a chain of 6 MAC cells per
//   output, 2 stages of rounding and unscaling, then the saturating output
//   register. The first stage loads at the accepting edge.
//   The pipeline advances as a whole; when the receiver stalls with a
//   forecast held, the whole pipeline freezes and in_ready drops, so
//   nothing is lost. Bubbles travel as cleared valid bits.
//   Synchronous reset clears the valid bits only; datapath is not reset.
//   in_ready is low while reset is held.
// ----------------------------------------------------------------------------
module mlp_price_forecast
  import mpf_pkg::*;
#(
  parameter int PRICE_FRAC_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_forecast_time,
  input  logic [31:0] in_open_price,
  input  logic [31:0] in_high_price,
  input  logic [31:0] in_low_price,
  input  logic [31:0] in_close_price,
  input  logic [31:0] in_tick_volume,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_out_time,
  output logic [31:0] out_pred_high,
  output logic [31:0] out_pred_low,
  output logic [31:0] out_pred_close
);

  localparam int Depth = 17;   // stages before the output register

  logic en;
  tag_t tag_r [Depth];
  logic [31:0] price_in [4];
  act_t z [NumIn];
  act_t z_d [NumIn][NumIn];    // delayed inputs feeding the hidden chains
  acc_t hsum [NumHid][NumIn+1];
  act_t h [NumHid];
  act_t h_d [NumHid][NumHid];
  acc_t osum [NumOut][NumHid+1];
  acc_t prod_r [NumOut];
  acc_t price_r [NumOut];
  logic [31:0] sat [NumOut];
  logic        out_valid_r;
  tag_t        out_tag;

  // pipeline moves when the output slot is empty or being drained
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en && rst_n;

  assign price_in[0] = in_open_price;
  assign price_in[1] = in_high_price;
  assign price_in[2] = in_low_price;
  assign price_in[3] = in_close_price;

  // valid/timestamp shift line alongside the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < Depth; s++) tag_r[s].valid <= 1'b0;
    end else if (en) begin
      tag_r[0].valid <= in_valid;
      for (int s = 1; s < Depth; s++) tag_r[s].valid <= tag_r[s-1].valid;
    end
    if (en) begin
      tag_r[0].tstamp <= in_forecast_time;
      for (int s = 1; s < Depth; s++) tag_r[s].tstamp <= tag_r[s-1].tstamp;
    end
  end

  mpf_norm #(.PRICE_FRAC_BITS(PRICE_FRAC_BITS)) u_norm (
    .clk   (clk),
    .en    (en),
    .t_in  (in_forecast_time),
    .p_in  (price_in),
    .v_in  (in_tick_volume),
    .z_out (z)
  );

  // skew the inputs and hidden outputs so value j meets cell j in the cycle after cell j-1
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < NumIn; j++) begin
        z_d[j][0] <= z[j];
        for (int d = 1; d < NumIn; d++) z_d[j][d] <= z_d[j][d-1];
      end
      for (int j = 0; j < NumHid; j++) begin
        h_d[j][0] <= h[j];
        for (int d = 1; d < NumHid; d++) h_d[j][d] <= h_d[j][d-1];
      end
    end
  end

  genvar gk, gj;
  generate
    for (gk = 0; gk < NumHid; gk++) begin : g_hid
      assign hsum[gk][0] = acc_t'(hid_w(gk, 0)) <<< 16;
      for (gj = 0; gj < NumIn; gj++) begin : g_cell
        mpf_mac_cell u_cell (
          .clk     (clk),
          .en      (en),
          .w       (hid_w(gk, gj + 1)),
          .x       ((gj == 0) ? z[0] : z_d[gj][(gj == 0) ? 0 : gj - 1]),
          .sum_in  (hsum[gk][gj]),
          .sum_out (hsum[gk][gj+1])
        );
      end
      mpf_tanh u_tanh (
        .clk    (clk),
        .en     (en),
        .acc_in (hsum[gk][NumIn]),
        .h_out  (h[gk])
      );
    end
    for (gk = 0; gk < NumOut; gk++) begin : g_out
      assign osum[gk][0] = acc_t'(out_w(gk, 0)) <<< 16;
      for (gj = 0; gj < NumHid; gj++) begin : g_cell
        mpf_mac_cell u_cell (
          .clk     (clk),
          .en      (en),
          .w       (out_w(gk, gj + 1)),
          .x       ((gj == 0) ? h[0] : h_d[gj][(gj == 0) ? 0 : gj - 1]),
          .sum_in  (osum[gk][gj]),
          .sum_out (osum[gk][gj+1])
        );
      end
    end
  endgenerate

  // unscale: product then add mean; saturation into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NumOut; k++) begin
        prod_r[k]  <= acc_t'(OutDev24[k]) * rnd_shift(osum[k][NumHid], 16);
        price_r[k] <= rnd_shift(acc_t'(OutMean30[k]), 30 - PRICE_FRAC_BITS)
                      + rnd_shift(prod_r[k], 40 - PRICE_FRAC_BITS);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NumOut; k++) begin
      if (price_r[k][63]) begin
        sat[k] = '0;
      end else if (price_r[k] > 64'sd4294967295) begin
        sat[k] = '1;
      end else begin
        sat[k] = price_r[k][31:0];
      end
    end
  end

  assign out_tag = tag_r[Depth-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= out_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_out_time   <= out_tag.tstamp;
      out_pred_high  <= sat[0];
      out_pred_low   <= sat[1];
      out_pred_close <= sat[2];
    end
  end

  assign out_valid = out_valid_r;

endmodule
